// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the xor trie counter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define XTCB_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same, on the block clock aclk and reset aresetn.
`define XTCB_ASSERT(label, prop, msg) \
    `XTCB_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== sv/xtcb_pkg.sv =====
// Shared types and constants of the xor trie counter.
// No dependencies; used by the top level and its checker.
package xtcb_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 30;
    localparam int COUNT_W  = 20;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

endpackage

// ===== sv/xtcb_ram.sv =====
// Generic synchronous RAM: one write port and two registered read ports.
// No dependencies.
module xtcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_a_addr,
    output logic [WIDTH-1:0] rd_a_data,
    input  logic [AW-1:0]    rd_b_addr,
    output logic [WIDTH-1:0] rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== sv/xor_trie_count_below.sv =====
// Binary trie multiset of keys with insert, erase and xor-below count query.
// Depends on xtcb_pkg and xtcb_ram.
//
// Each node (two child links and a pass count) sits in one word of a node RAM,
// walked one trie level per clock, most significant key bit first. A query
// reads one node per level on the first read port and the sibling count on
// the second, then drains and gives its result; it stops early where the
// path ends. Insert and erase make a checking walk, then a read-modify-write
// walk that writes each node while the next is read. An unused action goes
// straight to the result. Nodes at or above the allocation pointer read as
// zero, so no clearing pass follows reset and the block is ready in the cycle
// after reset is released. A new item may be taken while the previous result
// is still waiting on the m_ side.
module xor_trie_count_below #(
    parameter int KEY_BITS   = 30,
    parameter int MAX_NODES  = 65536,
    parameter int COUNT_BITS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [xtcb_pkg::ACTION_W-1:0] s_action,
    input  logic [xtcb_pkg::VALUE_W-1:0]  s_value,
    input  logic [xtcb_pkg::VALUE_W-1:0]  s_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xtcb_pkg::COUNT_W-1:0]  m_count,
    output logic [xtcb_pkg::STATUS_W-1:0] m_status
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NF_W   = $clog2(MAX_NODES + 1);
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int BIT_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int SUM_W  = NF_W + 1;
    localparam int WORD_W = 2 * NODE_W + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [LVL_W-1:0]      LVL_TOP   = LVL_W'(KEY_BITS);
    localparam logic [SUM_W-1:0]      POOL_SIZE = SUM_W'(MAX_NODES);

    typedef struct packed {
        logic [NODE_W-1:0]     one;
        logic [NODE_W-1:0]     zero;
        logic [COUNT_BITS-1:0] cnt;
    } node_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MODIFY,
        S_QUERY,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                state_reg,      state_next;
    xtcb_pkg::action_t     act_reg,        act_next;
    logic [KEY_BITS-1:0]   key_reg,        key_next;
    logic [KEY_BITS-1:0]   lim_reg,        lim_next;
    logic [LVL_W-1:0]      lvl_reg,        lvl_next;
    logic [NODE_W-1:0]     at_reg,         at_next;
    logic                  zero_reg,       zero_next;
    logic                  root_valid_reg, root_valid_next;
    logic [NF_W-1:0]       next_free_reg,  next_free_next;
    logic [COUNT_BITS-1:0] sum_reg,        sum_next;
    logic                  sib_pend_reg,   sib_pend_next;
    xtcb_pkg::status_t     res_status_reg, res_status_next;
    logic                  m_valid_reg,    m_valid_next;
    logic [xtcb_pkg::COUNT_W-1:0] m_count_reg, m_count_next;
    xtcb_pkg::status_t     m_status_reg,   m_status_next;

    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_t             wr_node;
    logic [NODE_W-1:0] ra_addr;
    logic [NODE_W-1:0] rb_addr;
    logic [WORD_W-1:0] ra_data;
    logic [WORD_W-1:0] rb_data;

    node_t             node;
    node_t             sib_node;
    logic [LVL_W-1:0]  lvl_m1;
    logic [BIT_W-1:0]  bit_idx;
    logic              kb;
    logic              lb;
    logic              walk_bit;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] sib_child;
    logic              at_leaf;
    logic              alloc;
    logic [NODE_W-1:0] down;
    logic [SUM_W-1:0]  need;
    logic [31:0]       val_wide;
    logic [31:0]       lim_wide;
    logic [31:0]       sum_wide;

    xtcb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk       (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_node),
        .rd_a_addr (ra_addr),
        .rd_a_data (ra_data),
        .rd_b_addr (rb_addr),
        .rd_b_data (rb_data)
    );

    // Nodes never allocated (and the root before its first write) read as empty.
    assign node     = zero_reg ? '0 : node_t'(ra_data);
    assign sib_node = node_t'(rb_data);

    assign lvl_m1    = lvl_reg - 1'b1;
    assign bit_idx   = lvl_m1[BIT_W-1:0];
    assign at_leaf   = (lvl_reg == '0);
    assign kb        = at_leaf ? 1'b0 : key_reg[bit_idx];
    assign lb        = at_leaf ? 1'b0 : lim_reg[bit_idx];
    assign walk_bit  = (state_reg == S_QUERY) ? (lb ^ kb) : kb;
    assign child     = walk_bit ? node.one : node.zero;
    assign sib_child = kb ? node.one : node.zero;
    assign alloc     = !at_leaf && (child == '0);
    assign down      = alloc ? next_free_reg[NODE_W-1:0] : child;
    assign need      = at_leaf ? '0 : SUM_W'(lvl_reg);

    assign val_wide = 32'(s_value);
    assign lim_wide = 32'(s_limit);
    assign sum_wide = 32'(sum_reg);

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_count  = m_count_reg;
    assign m_status = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        lim_next        = lim_reg;
        lvl_next        = lvl_reg;
        at_next         = at_reg;
        root_valid_next = root_valid_reg;
        next_free_next  = next_free_reg;
        sum_next        = sum_reg;
        sib_pend_next   = sib_pend_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        wr_en           = 1'b0;
        wr_addr         = at_reg;
        wr_node         = node;
        ra_addr         = '0;
        rb_addr         = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = xtcb_pkg::action_t'(s_action);
                    key_next        = val_wide[KEY_BITS-1:0];
                    lim_next        = lim_wide[KEY_BITS-1:0];
                    lvl_next        = LVL_TOP;
                    at_next         = '0;
                    sum_next        = '0;
                    sib_pend_next   = 1'b0;
                    res_status_next = xtcb_pkg::ST_OK;
                    case (xtcb_pkg::action_t'(s_action))
                        xtcb_pkg::ACT_INSERT: state_next = S_CHECK;
                        xtcb_pkg::ACT_ERASE:  state_next = S_CHECK;
                        xtcb_pkg::ACT_QUERY:  state_next = S_QUERY;
                        default:              state_next = S_FIN;
                    endcase
                end
            end

            S_CHECK: begin
                if (act_reg == xtcb_pkg::ACT_INSERT) begin
                    if (lvl_reg == LVL_TOP && node.cnt == CNT_MAX) begin
                        res_status_next = xtcb_pkg::ST_FULL;
                        state_next      = S_FIN;
                    end else if (at_leaf || child == '0) begin
                        // path ends here: the rest must fit in the pool
                        if (SUM_W'(next_free_reg) + need > POOL_SIZE) begin
                            res_status_next = xtcb_pkg::ST_FULL;
                            state_next      = S_FIN;
                        end else begin
                            lvl_next   = LVL_TOP;
                            at_next    = '0;
                            state_next = S_MODIFY;
                        end
                    end else begin
                        ra_addr  = child;
                        at_next  = child;
                        lvl_next = lvl_m1;
                    end
                end else begin
                    if (at_leaf) begin
                        if (node.cnt == '0) begin
                            res_status_next = xtcb_pkg::ST_ABSENT;
                            state_next      = S_FIN;
                        end else begin
                            lvl_next   = LVL_TOP;
                            at_next    = '0;
                            state_next = S_MODIFY;
                        end
                    end else if (child == '0) begin
                        res_status_next = xtcb_pkg::ST_ABSENT;
                        state_next      = S_FIN;
                    end else begin
                        ra_addr  = child;
                        at_next  = child;
                        lvl_next = lvl_m1;
                    end
                end
            end

            S_MODIFY: begin
                // write this node back while the next one is read
                wr_en = 1'b1;
                if (act_reg == xtcb_pkg::ACT_INSERT) begin
                    wr_node.cnt = node.cnt + 1'b1;
                    if (alloc) begin
                        if (kb) begin
                            wr_node.one = down;
                        end else begin
                            wr_node.zero = down;
                        end
                        next_free_next = next_free_reg + 1'b1;
                    end
                end else begin
                    wr_node.cnt = node.cnt - 1'b1;
                end
                if (at_reg == '0) begin
                    root_valid_next = 1'b1;
                end
                if (at_leaf) begin
                    res_status_next = xtcb_pkg::ST_OK;
                    state_next      = S_FIN;
                end else begin
                    ra_addr  = down;
                    at_next  = down;
                    lvl_next = lvl_m1;
                end
            end

            S_QUERY: begin
                if (sib_pend_reg) begin
                    sum_next = sum_reg + sib_node.cnt;
                end
                // count the whole subtree that stays below the limit
                sib_pend_next = lb && (sib_child != '0);
                rb_addr       = sib_child;
                if (at_leaf || child == '0) begin
                    state_next = S_DRAIN;
                end else begin
                    ra_addr  = child;
                    at_next  = child;
                    lvl_next = lvl_m1;
                end
            end

            S_DRAIN: begin
                if (sib_pend_reg) begin
                    sum_next = sum_reg + sib_node.cnt;
                end
                sib_pend_next   = 1'b0;
                res_status_next = xtcb_pkg::ST_OK;
                state_next      = S_FIN;
            end

            S_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_count_next  = sum_wide[xtcb_pkg::COUNT_W-1:0];
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        zero_next = (NF_W'(ra_addr) >= next_free_reg) || (ra_addr == '0 && !root_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            zero_reg       <= 1'b1;
            root_valid_reg <= 1'b0;
            next_free_reg  <= NF_W'(1);
            sib_pend_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            zero_reg       <= zero_next;
            root_valid_reg <= root_valid_next;
            next_free_reg  <= next_free_next;
            sib_pend_reg   <= sib_pend_next;
            m_valid_reg    <= m_valid_next;
        end
        act_reg        <= act_next;
        key_reg        <= key_next;
        lim_reg        <= lim_next;
        lvl_reg        <= lvl_next;
        at_reg         <= at_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// ===== sv/xtcb_checker.sv =====
// Port-level checks of the xor trie counter, bound to its top level.
// Depends on xtcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xtcb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [xtcb_pkg::ACTION_W-1:0] s_action,
    input logic [xtcb_pkg::VALUE_W-1:0]  s_value,
    input logic [xtcb_pkg::VALUE_W-1:0]  s_limit,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [xtcb_pkg::COUNT_W-1:0]  m_count,
    input logic [xtcb_pkg::STATUS_W-1:0] m_status
);

    // A result that waits keeps its payload.
    `XTCB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status), "result changed while stalled")

    `XTCB_ASSERT(a_status_code, m_valid |-> m_status == xtcb_pkg::ST_OK || m_status == xtcb_pkg::ST_ABSENT || m_status == xtcb_pkg::ST_FULL, "undefined status code")

    // Only a successful query carries a count.
    `XTCB_ASSERT(a_fail_count, m_valid && m_status != xtcb_pkg::ST_OK |-> m_count == '0, "count on a failed transfer")

    // One item at a time: the input side closes after each transfer.
    `XTCB_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "input taken while busy")

endmodule

bind xor_trie_count_below xtcb_checker u_xtcb_checker (.*);
